>>> hdl/plsc_pkg.sv
// Package: shared constants and types for the sensor calibrator.
`timescale 1ns / 1ps
package plsc_pkg;
    localparam int MAX_POINTS_DEF = 16;
    localparam int VW = 24;
    localparam int SW = 32;
    localparam int REG_IDX_W = 2;
    localparam int CFG_W = 32;

    localparam logic [1:0] KIND_CAL   = 2'd0;
    localparam logic [1:0] KIND_SET   = 2'd1;
    localparam logic [1:0] KIND_CLEAR = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_CLAMP = 2'd2;
    localparam logic [1:0] ST_SAT   = 2'd3;

    localparam logic [REG_IDX_W-1:0] REG_ZERO   = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_SCALE  = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_OFFSET = 2'd2;

    localparam logic signed [VW-1:0] V_MAX = 24'sh7FFFFF;
    localparam logic signed [VW-1:0] V_MIN = 24'sh800000;

    typedef logic signed [VW-1:0] val_t;

    // Per-cell report during a search sweep.
    typedef struct packed {
        logic valid;
        logic match;
        logic less;
        val_t meas;
        val_t act;
    } cell_view_t;
endpackage

>>> hdl/plsc_if.sv
// Interfaces: valid/ready channels for input items and result items.
`timescale 1ns / 1ps
interface plsc_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic signed [23:0] raw_value;
    logic signed [23:0] point_measured;
    logic signed [23:0] point_actual;
    modport source (output valid, kind, raw_value, point_measured, point_actual, input ready);
    modport sink   (input valid, kind, raw_value, point_measured, point_actual, output ready);
endinterface

interface plsc_out_if;
    logic       valid;
    logic       ready;
    logic signed [23:0] result_value;
    logic [1:0] status;
    logic [4:0] point_count;
    modport source (output valid, result_value, status, point_count, input ready);
    modport sink   (input valid, result_value, status, point_count, output ready);
endinterface

>>> hdl/piecewise_linear_sensor_calibrator.sv
// Top level: piecewise-linear height calibrator with a chain of table cells.
//
// Usage: items enter on in_ch (valid/ready); one result per item leaves on
// out_ch. Configuration is a plain write port (cfg_we, cfg_idx, cfg_data);
// the user must write it only while idle; the block itself does not enforce this.
// Table points live in a row of MAX_POINTS cells; on insert the cells at or
// above the slot shift right, keeping ascending measured order.
// From accept to result: clear, set-point, unused-kind and clamped items
// go EXEC, OUT; the linear fallback goes EXEC, MUL, FIN, OUT (one registered
// multiply, division by 65536 done as a shift); table interpolation goes
// EXEC, MUL, DST, DIV, FIN, OUT, starting and running a serial division.
// One item is in flight at a time; with no stall the next accept can come
// in the cycle after the result is taken. The serial divider makes table
// interpolation the slowest path.
// Reset empties the table and loads zero_point 0, height_scale 65536,
// height_offset 0. A result is held in the output register until taken;
// the next item is not accepted while it waits, only after the result is taken.
`timescale 1ns / 1ps
module piecewise_linear_sensor_calibrator #(
    parameter int MAX_POINTS = plsc_pkg::MAX_POINTS_DEF
) (
    input  logic clk,
    input  logic rst_n,
    plsc_in_if.sink    in_ch,
    plsc_out_if.source out_ch,
    input  logic                            cfg_we,
    input  logic [plsc_pkg::REG_IDX_W-1:0]  cfg_idx,
    input  logic [plsc_pkg::CFG_W-1:0]      cfg_data
);
    import plsc_pkg::*;

    localparam int CNTW = $clog2(MAX_POINTS + 1);
    localparam logic [2:0] S_IDLE = 3'd0, S_EXEC = 3'd1, S_MUL = 3'd2,
                           S_DIV = 3'd3, S_FIN = 3'd4, S_OUT = 3'd5,
                           S_DST = 3'd6;

    logic [2:0] state_reg;
    logic [1:0] kind_reg;
    val_t raw_reg, pm_reg, pa_reg;
    val_t zero_reg, off_reg;
    logic signed [SW-1:0] scale_reg;
    logic [CNTW-1:0] cnt_reg;
    logic fb_reg;
    val_t a0_reg;
    logic signed [VW:0] mdiff_reg, adiff_reg, den_reg;
    logic signed [63:0] prod_reg;
    logic signed [48:0] num_div;
    logic div_start, div_done;
    logic signed [48:0] quo;
    val_t res_reg;
    logic [1:0] st_reg;

    cell_view_t view [MAX_POINTS];
    cell_view_t leftv [MAX_POINTS];
    logic [MAX_POINTS-1:0] sel;
    logic any_match;
    logic accept;
    logic do_clear, do_ins, do_upd;

    assign accept = in_ch.valid && in_ch.ready;
    assign in_ch.ready = state_reg == S_IDLE;

    // key for cells: set uses measured; search for calibrate uses raw
    val_t key_m;
    assign key_m = (kind_reg == KIND_SET) ? pm_reg : raw_reg;

    always_comb
    begin
        any_match = 1'b0;
        for (int i = 0; i < MAX_POINTS; i++)
            any_match = any_match | view[i].match;
    end

    genvar g;
    generate
        for (g = 0; g < MAX_POINTS; g++)
        begin : g_cell
            if (g == 0)
                assign leftv[g] = '0;
            else
                assign leftv[g] = view[g-1];
            // slot: first cell whose left neighbor is less (or none) and itself is not less
            assign sel[g] = !view[g].less && (g == 0 ? 1'b1 : view[g-1].less);
            plsc_cell u_cell (
                .clk(clk), .rst_n(rst_n), .clear(do_clear), .ins_en(do_ins),
                .upd_en(do_upd), .sel_here(sel[g]), .key_m(key_m), .key_a(pa_reg),
                .left(leftv[g]), .view(view[g])
            );
        end
    endgenerate

    logic full;
    assign full = cnt_reg == CNTW'(MAX_POINTS);
    assign do_clear = state_reg == S_EXEC && kind_reg == KIND_CLEAR;
    assign do_upd   = state_reg == S_EXEC && kind_reg == KIND_SET && any_match;
    assign do_ins   = state_reg == S_EXEC && kind_reg == KIND_SET && !any_match && !full;

    // segment search: first i with m[i] <= raw <= m[i+1]
    logic seg_found;
    val_t s_m0, s_m1, s_a0, s_a1;
    always_comb
    begin
        seg_found = 1'b0;
        s_m0 = '0; s_m1 = '0; s_a0 = '0; s_a1 = '0;
        for (int i = MAX_POINTS - 2; i >= 0; i--)
        begin
            if (view[i+1].valid && raw_reg >= view[i].meas && raw_reg <= view[i+1].meas)
            begin
                seg_found = 1'b1;
                s_m0 = view[i].meas; s_m1 = view[i+1].meas;
                s_a0 = view[i].act;  s_a1 = view[i+1].act;
            end
        end
    end

    val_t last_act;
    always_comb
    begin
        last_act = view[0].act;
        for (int i = 1; i < MAX_POINTS; i++)
            if (view[i].valid)
                last_act = view[i].act;
    end

    logic signed [VW+1:0] fb_sum;
    logic signed [VW:0]   seg_sum;
    assign num_div = prod_reg[48:0];
    assign div_start = state_reg == S_DST;
    // fallback divides by 65536 truncating toward zero
    logic signed [63:0] fb_q;
    assign fb_q = (prod_reg[63] ? prod_reg + 64'sd65535 : prod_reg) >>> 16;
    assign fb_sum = 26'(fb_q) + 26'(off_reg);
    assign seg_sum = 25'(a0_reg) + 25'(quo);

    plsc_div #(.NW(49), .DW(VW + 1)) u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start), .num(num_div),
        .den(den_reg), .done(div_done), .quo(quo)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zero_reg  <= '0;
            scale_reg <= 32'sd65536;
            off_reg   <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                REG_ZERO:   zero_reg  <= cfg_data[VW-1:0];
                REG_SCALE:  scale_reg <= cfg_data;
                REG_OFFSET: off_reg   <= cfg_data[VW-1:0];
                default:    ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE: if (accept) state_reg <= S_EXEC;
                S_EXEC:
                begin
                    if (do_clear) cnt_reg <= '0;
                    if (do_ins) cnt_reg <= cnt_reg + 1'b1;
                    if (kind_reg == KIND_CAL && (fb_reg || seg_found))
                        state_reg <= S_MUL;
                    else
                        state_reg <= S_OUT;
                end
                S_MUL: state_reg <= fb_reg ? S_FIN : S_DST;
                S_DST: state_reg <= S_DIV;
                S_DIV: if (div_done) state_reg <= S_FIN;
                S_FIN: state_reg <= S_OUT;
                S_OUT: if (out_ch.ready) state_reg <= S_IDLE;
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg <= in_ch.kind;
            raw_reg  <= in_ch.raw_value;
            pm_reg   <= in_ch.point_measured;
            pa_reg   <= in_ch.point_actual;
            fb_reg   <= cnt_reg < CNTW'(2);
        end
        case (state_reg)
            S_EXEC:
            begin
                res_reg <= '0;
                st_reg  <= ST_OK;
                if (kind_reg == KIND_SET && !any_match && full)
                    st_reg <= ST_FULL;
                if (kind_reg == KIND_CAL && !fb_reg && !seg_found)
                begin
                    st_reg  <= ST_CLAMP;
                    res_reg <= (raw_reg < view[0].meas) ? view[0].act : last_act;
                end
                a0_reg    <= s_a0;
                mdiff_reg <= fb_reg ? 25'(raw_reg) - 25'(zero_reg)
                                    : 25'(raw_reg) - 25'(s_m0);
                adiff_reg <= 25'(s_a1) - 25'(s_a0);
                den_reg   <= (s_m1 > s_m0) ? 25'(s_m1) - 25'(s_m0) : 25'sd1;
            end
            S_MUL:
                prod_reg <= fb_reg ? 64'(mdiff_reg) * 64'(scale_reg)
                                   : 64'(mdiff_reg) * 64'(adiff_reg);
            S_FIN:
            begin
                if (fb_reg)
                begin
                    if (fb_q > 64'(V_MAX) - 64'(off_reg))
                    begin
                        res_reg <= V_MAX; st_reg <= ST_SAT;
                    end
                    else if (fb_q < 64'(V_MIN) - 64'(off_reg))
                    begin
                        res_reg <= V_MIN; st_reg <= ST_SAT;
                    end
                    else
                        res_reg <= fb_sum[VW-1:0];
                end
                else
                    res_reg <= seg_sum[VW-1:0];
            end
            default: ;
        endcase
    end

    assign out_ch.valid        = state_reg == S_OUT;
    assign out_ch.result_value = res_reg;
    assign out_ch.status       = st_reg;
    assign out_ch.point_count  = 5'(cnt_reg);

    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNTW'(MAX_POINTS)) else $error("point count overflow");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_IDLE |-> !in_ch.ready) else $error("ready while busy");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(res_reg))
        else $error("result dropped");
    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == S_DIV) else $error("stray divider done");
endmodule

>>> hdl/plsc_cell.sv
// Calibration cell: one table entry that shifts right on insert.
`timescale 1ns / 1ps
module plsc_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                clear,
    input  logic                ins_en,
    input  logic                upd_en,
    input  logic                sel_here,
    input  plsc_pkg::val_t      key_m,
    input  plsc_pkg::val_t      key_a,
    input  plsc_pkg::cell_view_t left,
    output plsc_pkg::cell_view_t view
);
    import plsc_pkg::*;

    logic valid_reg;
    val_t meas_reg;
    val_t act_reg;
    logic shift_in;
    logic left_moves;

    // a valid left neighbor at or above the slot moves one place right
    assign left_moves = left.valid && !left.less;

    // insert: cells at or above the slot take the left neighbor, the slot takes the key
    assign shift_in = ins_en && (valid_reg ? !view.less : left_moves);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (clear)
            valid_reg <= 1'b0;
        else if (ins_en && (valid_reg || sel_here || left_moves))
            valid_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (ins_en && sel_here)
        begin
            meas_reg <= key_m;
            act_reg  <= key_a;
        end
        else if (shift_in)
        begin
            meas_reg <= left.meas;
            act_reg  <= left.act;
        end
        else if (upd_en && valid_reg && meas_reg == key_m)
            act_reg <= key_a;
    end

    assign view.valid = valid_reg;
    assign view.match = valid_reg && meas_reg == key_m;
    assign view.less  = valid_reg && meas_reg < key_m;
    assign view.meas  = meas_reg;
    assign view.act   = act_reg;
endmodule

>>> hdl/plsc_div.sv
// Serial signed divider: restoring, one quotient bit per cycle, truncates toward zero.
`timescale 1ns / 1ps
module plsc_div #(
    parameter int NW = 48,
    parameter int DW = 25
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic signed [NW-1:0] num,
    input  logic signed [DW-1:0] den,
    output logic                 done,
    output logic signed [NW-1:0] quo
);
    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] q_reg, q_next;
    logic [DW:0]   r_reg, r_next;
    logic [DW-1:0] d_reg;
    logic          neg_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic [DW:0]   trial;

    always_comb
    begin
        trial  = {r_reg[DW-1:0], q_reg[NW-1]};
        r_next = trial;
        q_next = {q_reg[NW-2:0], 1'b0};
        if (trial >= {1'b0, d_reg})
        begin
            r_next    = trial - {1'b0, d_reg};
            q_next[0] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done     <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(NW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done     <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= num[NW-1] ? NW'(-num) : num;
            d_reg   <= den[DW-1] ? DW'(-den) : den;
            r_reg   <= '0;
            neg_reg <= num[NW-1] ^ den[DW-1];
        end
        else if (busy_reg)
        begin
            q_reg <= q_next;
            r_reg <= r_next;
        end
    end

    assign quo = neg_reg ? NW'(-$signed(q_reg)) : $signed(q_reg);
endmodule
